FILE: rtl/bts_pkg.sv
// Shared types and constants for the bilinear texture sampler.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bts_pkg;

    localparam int COL_W       = 8;
    localparam int ROW_W       = 8;
    localparam int MAX_COLS    = 1 << COL_W;
    localparam int MAX_ROWS    = 1 << ROW_W;
    localparam int CH_W        = 16;
    localparam int FRAC_W      = 16;
    localparam int COORD_W     = FRAC_W + 1;
    localparam int SIZE_W      = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int NUM_CH      = 3;
    localparam int NUM_BANKS   = 4;
    localparam int BANK_ADDR_W = (COL_W - 1) + (ROW_W - 1);

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(MAX_COLS);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(MAX_ROWS);

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef logic signed [CH_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0] pixel_t;

endpackage

`default_nettype wire

FILE: rtl/bts_coord.sv
// Coordinate unit: scales one coordinate by size minus one, subtracts one half,
// and splits it into two clamped corner indices and a fraction. Uses bts_pkg.
`default_nettype none

module bts_coord #(
    parameter int IDX_W = bts_pkg::COL_W
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [bts_pkg::SIZE_W-1:0]   size,
    input  wire logic [bts_pkg::COORD_W-1:0]  coord,
    output logic      [IDX_W-1:0]             lo,
    output logic      [IDX_W-1:0]             hi,
    output logic      [bts_pkg::FRAC_W-1:0]   frac
);

    localparam int SIZE_W = bts_pkg::SIZE_W;
    localparam int FRAC_W = bts_pkg::FRAC_W;
    localparam int MAXV   = 1 << IDX_W;
    localparam int PROD_W = bts_pkg::COORD_W + IDX_W;
    localparam int P_W    = PROD_W + 1;
    localparam int I_W    = P_W - FRAC_W;
    localparam logic [P_W-1:0] HALF = P_W'(1) << (FRAC_W - 1);

    logic [SIZE_W-1:0]        size_lim;
    logic [IDX_W-1:0]         size_m1;
    logic [PROD_W-1:0]        prod;
    logic signed [P_W-1:0]    p_next;
    logic signed [P_W-1:0]    p_reg;
    logic signed [I_W-1:0]    i0;
    logic signed [I_W-1:0]    i1;
    logic signed [I_W-1:0]    lim;
    logic [IDX_W-1:0]         lo_next;
    logic [IDX_W-1:0]         hi_next;
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic [FRAC_W-1:0]        frac_reg;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [I_W-1:0] v,
                                                   input logic signed [I_W-1:0] top);
        logic [IDX_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > top)
        begin
            r = top[IDX_W-1:0];
        end
        else
        begin
            r = v[IDX_W-1:0];
        end
        return r;
    endfunction

    // A size of zero acts as one; a size above the store acts as the store size.
    always_comb
    begin
        if (size == '0)
        begin
            size_lim = SIZE_W'(1);
        end
        else if (size > SIZE_W'(MAXV))
        begin
            size_lim = SIZE_W'(MAXV);
        end
        else
        begin
            size_lim = size;
        end
        size_m1 = IDX_W'(size_lim - SIZE_W'(1));
    end

    assign prod   = PROD_W'(coord) * PROD_W'(size_m1);
    assign p_next = $signed({1'b0, prod}) - $signed(HALF);

    // The upper bits of p form the floor toward minus infinity.
    assign i0      = p_reg[P_W-1:FRAC_W];
    assign i1      = i0 + I_W'(1);
    assign lim     = $signed({{(I_W - IDX_W){1'b0}}, size_m1});
    assign lo_next = clamp_idx(i0, lim);
    assign hi_next = clamp_idx(i1, lim);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            frac_reg <= p_reg[FRAC_W-1:0];
        end
    end

    assign lo   = lo_reg;
    assign hi   = hi_reg;
    assign frac = frac_reg;

endmodule

`default_nettype wire

FILE: rtl/bts_store.sv
// Pixel store split into four banks by column and row parity, so that all
// four corners of a 2x2 footprint are read in the same cycle. Uses bts_pkg.
`default_nettype none

module bts_store (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic                        wr_en,
    input  wire logic [bts_pkg::COL_W-1:0]   wr_col,
    input  wire logic [bts_pkg::ROW_W-1:0]   wr_row,
    input  wire bts_pkg::pixel_t             wr_pixel,
    input  wire logic [bts_pkg::COL_W-1:0]   x0,
    input  wire logic [bts_pkg::COL_W-1:0]   x1,
    input  wire logic [bts_pkg::ROW_W-1:0]   y0,
    input  wire logic [bts_pkg::ROW_W-1:0]   y1,
    output bts_pkg::pixel_t                  p00,
    output bts_pkg::pixel_t                  p01,
    output bts_pkg::pixel_t                  p10,
    output bts_pkg::pixel_t                  p11
);

    localparam int COL_W  = bts_pkg::COL_W;
    localparam int ROW_W  = bts_pkg::ROW_W;
    localparam int BA_W   = bts_pkg::BANK_ADDR_W;
    localparam int NB     = bts_pkg::NUM_BANKS;
    localparam int DEPTH  = 1 << BA_W;

    typedef struct packed {
        logic x0;
        logic x1;
        logic y0;
        logic y1;
    } corner_par_t;

    logic [BA_W-1:0]   rd_addr [NB];
    logic [BA_W-1:0]   wr_addr;
    logic [1:0]        wr_bank;
    bts_pkg::pixel_t   q_reg [NB];
    corner_par_t       par_reg;

    assign wr_addr = {wr_row[ROW_W-1:1], wr_col[COL_W-1:1]};
    assign wr_bank = {wr_row[0], wr_col[0]};

    // Each bank takes whichever corner column and row match its parity.
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            logic [1:0]       bsel;
            logic [COL_W-1:0] col;
            logic [ROW_W-1:0] row;
            bsel = 2'(b);
            col  = (x0[0] == bsel[0]) ? x0 : x1;
            row  = (y0[0] == bsel[1]) ? y0 : y1;
            rd_addr[b] = {row[ROW_W-1:1], col[COL_W-1:1]};
        end
    end

    for (genvar b = 0; b < NB; b++)
    begin : g_bank
        bts_pkg::pixel_t mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(b)))
            begin
                mem[wr_addr] <= wr_pixel;
            end
            if (en)
            begin
                q_reg[b] <= mem[rd_addr[b]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg <= '{x0: x0[0], x1: x1[0], y0: y0[0], y1: y1[0]};
        end
    end

    assign p00 = q_reg[{par_reg.y0, par_reg.x0}];
    assign p01 = q_reg[{par_reg.y0, par_reg.x1}];
    assign p10 = q_reg[{par_reg.y1, par_reg.x0}];
    assign p11 = q_reg[{par_reg.y1, par_reg.x1}];

endmodule

`default_nettype wire

FILE: rtl/bts_lerp.sv
// One registered blend step of a single channel: a + floor((b - a) * t).
// The product is truncated toward minus infinity. Uses bts_pkg.
`default_nettype none

module bts_lerp (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire bts_pkg::chan_t             a,
    input  wire bts_pkg::chan_t             b,
    input  wire logic [bts_pkg::FRAC_W-1:0] t,
    output bts_pkg::chan_t                  y
);

    localparam int CH_W   = bts_pkg::CH_W;
    localparam int FRAC_W = bts_pkg::FRAC_W;
    localparam int PR_W   = (CH_W + 1) + (FRAC_W + 1);

    logic signed [CH_W:0]   diff;
    logic signed [PR_W-1:0] prod;
    logic [CH_W-1:0]        y_next;
    logic [CH_W-1:0]        y_reg;

    assign diff   = $signed({b[CH_W-1], b}) - $signed({a[CH_W-1], a});
    assign prod   = diff * $signed({1'b0, t});
    assign y_next = a + prod[FRAC_W+CH_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = $signed(y_reg);

endmodule

`default_nettype wire

FILE: rtl/bilinear_texture_sampler_unit.sv
// Top level of the bilinear texture sampler with clamp-to-edge addressing.
// Depends on bts_pkg, bts_coord, bts_store and bts_lerp.
//
//   Channel   Handshake              Payload
//   request   req_valid / req_stall  func, pixel_x, pixel_y, red_in, green_in,
//                                    blue_in, coord_u, coord_v
//   response  rsp_valid / rsp_stall  red_out, green_out, blue_out
//   config    cfg_wr_en              cfg_index, cfg_data
//
// One item is taken per cycle while no response is stalled. A sample passes through
// the registered stages scale, split and clamp, parity-banked 2x2 store read,
// blend along x and blend along y. A write lands in the store at its store read
// stage and gives no response. A stalled response freezes the whole pipeline and
// holds the request side. Reset clears the valid bits and sets both size registers
// to 256; the pixel store is not cleared.
`default_nettype none

module bilinear_texture_sampler_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic                            func,
    input  wire logic [7:0]                      pixel_x,
    input  wire logic [7:0]                      pixel_y,
    input  wire logic signed [15:0]              red_in,
    input  wire logic signed [15:0]              green_in,
    input  wire logic signed [15:0]              blue_in,
    input  wire logic [bts_pkg::COORD_W-1:0]     coord_u,
    input  wire logic [bts_pkg::COORD_W-1:0]     coord_v,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic signed [15:0]                   red_out,
    output logic signed [15:0]                   green_out,
    output logic signed [15:0]                   blue_out,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bts_pkg::SIZE_W-1:0]      cfg_data
);

    localparam int COL_W  = bts_pkg::COL_W;
    localparam int ROW_W  = bts_pkg::ROW_W;
    localparam int FRAC_W = bts_pkg::FRAC_W;
    localparam int SIZE_W = bts_pkg::SIZE_W;
    localparam int NUM_CH = bts_pkg::NUM_CH;

    logic                  en;
    logic [SIZE_W-1:0]     image_width_reg;
    logic [SIZE_W-1:0]     image_height_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  v4_reg;
    logic                  v5_reg;
    logic                  v4_next;
    logic                  func1_reg;
    logic                  func2_reg;
    logic                  func3_reg;
    logic [COL_W-1:0]      wcol1_reg;
    logic [COL_W-1:0]      wcol2_reg;
    logic [ROW_W-1:0]      wrow1_reg;
    logic [ROW_W-1:0]      wrow2_reg;
    bts_pkg::pixel_t       wpix_next;
    bts_pkg::pixel_t       wpix1_reg;
    bts_pkg::pixel_t       wpix2_reg;
    logic [FRAC_W-1:0]     tx3_reg;
    logic [FRAC_W-1:0]     ty3_reg;
    logic [FRAC_W-1:0]     ty4_reg;
    logic [COL_W-1:0]      x0;
    logic [COL_W-1:0]      x1;
    logic [ROW_W-1:0]      y0;
    logic [ROW_W-1:0]      y1;
    logic [FRAC_W-1:0]     tx;
    logic [FRAC_W-1:0]     ty;
    logic                  store_wr;
    bts_pkg::pixel_t       p00;
    bts_pkg::pixel_t       p01;
    bts_pkg::pixel_t       p10;
    bts_pkg::pixel_t       p11;
    bts_pkg::pixel_t       r0;
    bts_pkg::pixel_t       r1;
    bts_pkg::pixel_t       res;

    assign en        = !(v5_reg && rsp_stall);
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bts_pkg::WIDTH_RESET;
            image_height_reg <= bts_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bts_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                bts_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign v4_next = v3_reg && (func3_reg == bts_pkg::FUNC_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v4_next;
            v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        wpix_next                  = '0;
        wpix_next[bts_pkg::CH_RED]   = red_in;
        wpix_next[bts_pkg::CH_GREEN] = green_in;
        wpix_next[bts_pkg::CH_BLUE]  = blue_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= func;
            func2_reg <= func1_reg;
            func3_reg <= func2_reg;
            wcol1_reg <= pixel_x;
            wcol2_reg <= wcol1_reg;
            wrow1_reg <= pixel_y;
            wrow2_reg <= wrow1_reg;
            wpix1_reg <= wpix_next;
            wpix2_reg <= wpix1_reg;
            tx3_reg   <= tx;
            ty3_reg   <= ty;
            ty4_reg   <= ty3_reg;
        end
    end

    bts_coord #(
        .IDX_W (COL_W)
    ) u_coord_x (
        .clk   (clk),
        .en    (en),
        .size  (image_width_reg),
        .coord (coord_u),
        .lo    (x0),
        .hi    (x1),
        .frac  (tx)
    );

    bts_coord #(
        .IDX_W (ROW_W)
    ) u_coord_y (
        .clk   (clk),
        .en    (en),
        .size  (image_height_reg),
        .coord (coord_v),
        .lo    (y0),
        .hi    (y1),
        .frac  (ty)
    );

    assign store_wr = en && v2_reg && (func2_reg == bts_pkg::FUNC_WRITE);

    bts_store u_store (
        .clk      (clk),
        .en       (en),
        .wr_en    (store_wr),
        .wr_col   (wcol2_reg),
        .wr_row   (wrow2_reg),
        .wr_pixel (wpix2_reg),
        .x0       (x0),
        .x1       (x1),
        .y0       (y0),
        .y1       (y1),
        .p00      (p00),
        .p01      (p01),
        .p10      (p10),
        .p11      (p11)
    );

    for (genvar k = 0; k < NUM_CH; k++)
    begin : g_chan
        bts_lerp u_lerp_top (
            .clk (clk),
            .en  (en),
            .a   (p00[k]),
            .b   (p01[k]),
            .t   (tx3_reg),
            .y   (r0[k])
        );

        bts_lerp u_lerp_bot (
            .clk (clk),
            .en  (en),
            .a   (p10[k]),
            .b   (p11[k]),
            .t   (tx3_reg),
            .y   (r1[k])
        );

        bts_lerp u_lerp_vert (
            .clk (clk),
            .en  (en),
            .a   (r0[k]),
            .b   (r1[k]),
            .t   (ty4_reg),
            .y   (res[k])
        );
    end

    assign rsp_valid = v5_reg;
    assign red_out   = res[bts_pkg::CH_RED];
    assign green_out = res[bts_pkg::CH_GREEN];
    assign blue_out  = res[bts_pkg::CH_BLUE];

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for bilinear_texture_sampler_unit: writes texels, samples them
// and compares each interpolated color with a clamp-to-edge bilinear predictor held here.
// Depends on bts_pkg and the RTL of the block.

module tb_top;
    import bts_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1 << FRAC_W);
    localparam logic [COORD_W-1:0] COORD_HALF = COORD_W'(1 << (FRAC_W - 1));
    localparam logic [COORD_W-1:0] COORD_TOP = '1;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    logic func;
    logic [COL_W-1:0] pixel_x;
    logic [ROW_W-1:0] pixel_y;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;
    logic rsp_valid;
    logic rsp_stall;
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    pixel_t texels [int];
    pixel_t pending_colors [$];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_req = 0;
    int items_sent = 0;
    int fail_count = 0;

    bilinear_texture_sampler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .coord_u   (coord_u),
        .coord_v   (coord_v),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int used_size(logic [SIZE_W-1:0] r, int max_size);
        if (r == 0)
            return 1;
        if (r > max_size)
            return max_size;
        return int'(r);
    endfunction

    function automatic int clamp_index(longint i, int size);
        if (i < 0)
            return 0;
        if (i > size - 1)
            return size - 1;
        return int'(i);
    endfunction

    function automatic void locate(input logic [COORD_W-1:0] c, input int size,
                                   output int lo, output int hi, output longint frac);
        longint p;
        longint i;
        p = longint'(c) * (size - 1) - longint'(COORD_HALF);
        i = p >>> FRAC_W;
        frac = p - (i <<< FRAC_W);
        lo = clamp_index(i, size);
        hi = clamp_index(i + 1, size);
    endfunction

    function automatic longint mix(longint a, longint b, longint t);
        return a + (((b - a) * t) >>> FRAC_W);
    endfunction

    function automatic pixel_t bilinear_color(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int x0, x1, y0, y1;
        longint tx, ty, top, bottom;
        pixel_t c;
        locate(u, used_size(width_reg, MAX_COLS), x0, x1, tx);
        locate(v, used_size(height_reg, MAX_ROWS), y0, y1, ty);
        for (int k = 0; k < NUM_CH; k++)
        begin
            top = mix(texels[y0 * MAX_COLS + x0][k], texels[y0 * MAX_COLS + x1][k], tx);
            bottom = mix(texels[y1 * MAX_COLS + x0][k], texels[y1 * MAX_COLS + x1][k], tx);
            c[k] = chan_t'(mix(top, bottom, ty));
        end
        return c;
    endfunction

    function automatic pixel_t random_color();
        pixel_t c;
        for (int k = 0; k < NUM_CH; k++)
            c[k] = chan_t'($urandom_range(0, 65535));
        return c;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? COORD_TOP : COORD_ONE;
            1: return COORD_W'($urandom_range(COORD_ONE + 1, COORD_TOP));
            default: return COORD_W'($urandom_range(0, COORD_ONE));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:
            begin
                if ($urandom_range(0, 1) != 0)
                    return '0;
                return SIZE_W'($urandom_range(MAX_COLS + 1, (1 << SIZE_W) - 1));
            end
            1, 2: return SIZE_W'($urandom_range(17, MAX_COLS));
            default: return SIZE_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic send_item(func_t f, logic [COL_W-1:0] x, logic [ROW_W-1:0] y, pixel_t c,
                             logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        func <= f;
        pixel_x <= x;
        pixel_y <= y;
        red_in <= c[CH_RED];
        green_in <= c[CH_GREEN];
        blue_in <= c[CH_BLUE];
        coord_u <= u;
        coord_v <= v;
        do
            @(posedge clk);
        while (req_stall);
        if (f == FUNC_WRITE)
            texels[int'(y) * MAX_COLS + int'(x)] = c;
        else
            pending_colors.insert(pending_colors.size(), bilinear_color(u, v));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_pixel(int x, int y, pixel_t c);
        send_item(FUNC_WRITE, COL_W'(x), ROW_W'(y), c, random_coord(), random_coord());
    endtask

    // Every texel that the sample blends is written first, so no undefined entry is read.
    task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int x0, x1, y0, y1, xx, yy;
        longint tx, ty;
        locate(u, used_size(width_reg, MAX_COLS), x0, x1, tx);
        locate(v, used_size(height_reg, MAX_ROWS), y0, y1, ty);
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                xx = (i != 0) ? x1 : x0;
                yy = (j != 0) ? y1 : y0;
                if (!texels.exists(yy * MAX_COLS + xx))
                    write_pixel(xx, yy, random_color());
            end
        end
        send_item(FUNC_SAMPLE, COL_W'($urandom), ROW_W'($urandom), random_color(), u, v);
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        width_reg = w;
        height_reg = h;
    endtask

    task automatic test_edge_values();
        pixel_t c;
        c[CH_RED] = 16'sh7fff;
        c[CH_GREEN] = 16'sh8000;
        c[CH_BLUE] = 16'sh0000;
        write_pixel(0, 0, c);
        write_pixel(MAX_COLS - 1, MAX_ROWS - 1, c);
        c[CH_RED] = 16'sh8000;
        c[CH_GREEN] = 16'sh7fff;
        c[CH_BLUE] = 16'shffff;
        write_pixel(1, 0, c);
        write_pixel(MAX_COLS - 1, 0, c);
        write_pixel(0, MAX_ROWS - 1, c);
        sample_at(0, 0);
        sample_at(COORD_ONE, COORD_ONE);
        sample_at(COORD_TOP, COORD_TOP);
        sample_at(0, COORD_TOP);
        sample_at(COORD_HALF, COORD_HALF);
        // Fraction close to one between the two most distant channel values.
        sample_at(385, 0);
        // A write immediately followed by a sample of the same texel.
        write_pixel(0, 0, random_color());
        sample_at(0, 0);
    endtask

    task automatic test_size_registers();
        logic [SIZE_W-1:0] widths [5];
        logic [SIZE_W-1:0] heights [5];
        widths = '{9'd0, 9'd1, 9'd2, 9'd511, 9'd257};
        heights = '{9'd1, 9'd0, 9'd511, 9'd2, 9'd3};
        for (int i = 0; i < 5; i++)
        begin
            set_size(widths[i], heights[i]);
            sample_at(0, COORD_ONE);
            sample_at(COORD_TOP, random_coord());
        end
    endtask

    task automatic test_backpressure();
        set_size(8, 8);
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_req = HOLD_CYCLES;
        repeat (40) sample_at(random_coord(), random_coord());
        wait_drain();
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pct, int quota);
        int start;
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            set_size(random_size(), random_size());
            for (int n = 0; n < 120 && items_sent - start < quota; n++)
            begin
                if ($urandom_range(0, 99) < 30)
                    write_pixel($urandom_range(0, MAX_COLS - 1), $urandom_range(0, MAX_ROWS - 1),
                                random_color());
                else
                    sample_at(random_coord(), random_coord());
            end
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
        end
    end

    initial
    begin : color_check
        pixel_t got;
        pixel_t want;
        string names [NUM_CH];
        names[CH_RED] = "red_out";
        names[CH_GREEN] = "green_out";
        names[CH_BLUE] = "blue_out";
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                got[CH_RED] = red_out;
                got[CH_GREEN] = green_out;
                got[CH_BLUE] = blue_out;
                if (pending_colors.size() == 0)
                begin
                    $error("color transfer with no sample pending: %0d %0d %0d",
                           red_out, green_out, blue_out);
                    fail_count++;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    for (int k = 0; k < NUM_CH; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            $error("%s: expected %0d, actual %0d", names[k], want[k], got[k]);
                            fail_count++;
                        end
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : run
        rst_n = 1'b0;
        req_valid = 1'b0;
        func = FUNC_WRITE;
        pixel_x = '0;
        pixel_y = '0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        coord_u = '0;
        coord_v = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_edge_values();
        test_size_registers();
        test_backpressure();
        test_random_traffic(32, 86, 525);
        test_random_traffic(86, 32, 525);
        test_random_traffic(0, 0, 525);
        wait_drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bts_pkg.sv
rtl/bts_coord.sv
rtl/bts_store.sv
rtl/bts_lerp.sv
rtl/bilinear_texture_sampler_unit.sv
tb/tb_top.sv
